>>> design/complex_matrix_multiply_5x5_unit_assert.svh
// Assertion macros shared by the checker of the complex matrix multiply unit.
// No dependencies; included by the checker file only.
`ifndef COMPLEX_MATRIX_MULTIPLY_5X5_UNIT_ASSERT_SVH
`define COMPLEX_MATRIX_MULTIPLY_5X5_UNIT_ASSERT_SVH

// Check that pre implies post in the same cycle
`define CMM_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cmm assertion failed");

// Check that pre implies post in the next cycle
`define CMM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cmm assertion failed");

`endif

>>> design/cmm_pkg.sv
// Package of the complex matrix multiply unit: mode codes, field widths and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package cmm_pkg;

  // Fixed field widths of the result item
  localparam int unsigned OP_W  = 2;
  localparam int unsigned C_W   = 36;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned OUT_TDATA_W = 80;

  // Mode codes; the unused code runs as plain A*B
  typedef enum logic [OP_W-1:0] {
    OP_AB  = 2'd0,
    OP_ABH = 2'd1,
    OP_AHB = 2'd2
  } op_e;

  // Controller state, one-hot
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Tags that travel with each issued multiply-accumulate step
  typedef struct packed {
    logic             issue;
    logic             first;
    logic             last_k;
    logic             last_el;
    logic             conj_a;
    logic             conj_b;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic adv;
    logic done;
  } stat_t;

endpackage

`default_nettype wire

>>> design/cmm_ctrl.sv
// Controller of the complex matrix multiply unit: load counter, mode latch and
// the row/column/inner-index sequencer. Depends on cmm_pkg.
`default_nettype none

module cmm_ctrl #(
  parameter int unsigned DIM = 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_accept_i,
  input  wire  [cmm_pkg::OP_W-1:0]     in_op_i,
  output logic                         in_ready_o,
  output logic                         wr_en_o,
  output logic [$clog2(DIM*DIM)-1:0]   wr_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]   rd_a_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]   rd_b_addr_o,
  output cmm_pkg::cmd_t                cmd_o,
  input  cmm_pkg::stat_t               stat_i
);
  import cmm_pkg::*;

  localparam int unsigned N  = DIM * DIM;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned IW = $clog2(DIM);
  localparam logic [AW-1:0] DIM_A  = AW'(DIM);
  localparam logic [AW-1:0] LAST_A = AW'(N - 1);
  localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          conj_a_q, conj_a_d, conj_b_q, conj_b_d;
  logic          issue;
  logic          last_k, last_j, last_i;

  assign in_ready_o = (state_q == ST_LOAD);
  assign wr_en_o    = in_accept_i;
  assign wr_addr_o  = cnt_q;

  assign issue  = (state_q == ST_RUN) && stat_i.adv;
  assign last_k = (k_q == LAST_I);
  assign last_j = (j_q == LAST_I);
  assign last_i = (i_q == LAST_I);

  // Form read addresses for the selected mode
  always_comb begin
    rd_a_addr_o = conj_a_q ? (AW'(k_q) * DIM_A + AW'(i_q)) : (AW'(i_q) * DIM_A + AW'(k_q));
    rd_b_addr_o = conj_b_q ? (AW'(j_q) * DIM_A + AW'(k_q)) : (AW'(k_q) * DIM_A + AW'(j_q));
  end

  // Build the step command
  always_comb begin
    cmd_o.issue   = issue;
    cmd_o.first   = (k_q == '0);
    cmd_o.last_k  = last_k;
    cmd_o.last_el = last_k && last_j && last_i;
    cmd_o.conj_a  = conj_a_q;
    cmd_o.conj_b  = conj_b_q;
    cmd_o.row     = IDX_W'(i_q);
    cmd_o.col     = IDX_W'(j_q);
  end

  // Sequence loading, computing and draining
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    conj_a_d = conj_a_q;
    conj_b_d = conj_b_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept_i) begin
          if (cnt_q == LAST_A) begin
            cnt_d   = '0;
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = ST_RUN;
            case (op_e'(in_op_i))
              OP_ABH: begin
                conj_a_d = 1'b0;
                conj_b_d = 1'b1;
              end
              OP_AHB: begin
                conj_a_d = 1'b1;
                conj_b_d = 1'b0;
              end
              default: begin
                conj_a_d = 1'b0;
                conj_b_d = 1'b0;
              end
            endcase
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (!last_k) begin
            k_d = k_q + 1'b1;
          end else begin
            k_d = '0;
            if (!last_j) begin
              j_d = j_q + 1'b1;
            end else begin
              j_d = '0;
              if (!last_i) begin
                i_d = i_q + 1'b1;
              end else begin
                state_d = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (stat_i.done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      conj_a_q <= 1'b0;
      conj_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      conj_a_q <= conj_a_d;
      conj_b_q <= conj_b_d;
    end
  end

endmodule

`default_nettype wire

>>> design/cmm_dp.sv
// Datapath of the complex matrix multiply unit: A and B element memories,
// complex multiplier, accumulator and output register. Depends on cmm_pkg.
`default_nettype none

module cmm_dp #(
  parameter int unsigned DIM        = 5,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          wr_en_i,
  input  wire  [$clog2(DIM*DIM)-1:0]   wr_addr_i,
  input  wire  [ELEM_WIDTH-1:0]        a_re_i,
  input  wire  [ELEM_WIDTH-1:0]        a_im_i,
  input  wire  [ELEM_WIDTH-1:0]        b_re_i,
  input  wire  [ELEM_WIDTH-1:0]        b_im_i,
  input  wire  [$clog2(DIM*DIM)-1:0]   rd_a_addr_i,
  input  wire  [$clog2(DIM*DIM)-1:0]   rd_b_addr_i,
  input  cmm_pkg::cmd_t                cmd_i,
  output cmm_pkg::stat_t               stat_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [cmm_pkg::C_W-1:0]      c_re_o,
  output logic [cmm_pkg::C_W-1:0]      c_im_o,
  output logic [cmm_pkg::IDX_W-1:0]    row_o,
  output logic [cmm_pkg::IDX_W-1:0]    col_o,
  output logic                         last_o
);
  import cmm_pkg::*;

  localparam int unsigned N  = DIM * DIM;
  localparam int unsigned EW = ELEM_WIDTH;
  localparam int unsigned PW = 2 * ELEM_WIDTH;

  logic [2*EW-1:0] a_mem [N];
  logic [2*EW-1:0] b_mem [N];
  logic [2*EW-1:0] a_rd_q, b_rd_q;
  cmd_t            cmd1_q, cmd2_q;

  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [C_W-1:0] rr, ii, ri, ir;
  logic signed [C_W-1:0] term_re, term_im, sum_re, sum_im;
  logic signed [C_W-1:0] acc_re_q, acc_im_q;

  logic            out_valid_q;
  logic [C_W-1:0]  c_re_q, c_im_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic            last_q;
  logic            adv;

  // Stall every stage while the output item waits
  assign adv = !out_valid_q || out_ready_i;
  assign stat_o.adv  = adv;
  assign stat_o.done = out_valid_q && out_ready_i && last_q;

  // Store loaded elements, imaginary part in the upper half
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      a_mem[wr_addr_i] <= {a_im_i, a_re_i};
      b_mem[wr_addr_i] <= {b_im_i, b_re_i};
    end
  end

  // Read operands
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rd_q <= a_mem[rd_a_addr_i];
      b_rd_q <= b_mem[rd_b_addr_i];
    end
  end

  // Multiply the four partial products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_rr_q <= $signed(a_rd_q[EW-1:0])    * $signed(b_rd_q[EW-1:0]);
      p_ii_q <= $signed(a_rd_q[2*EW-1:EW]) * $signed(b_rd_q[2*EW-1:EW]);
      p_ri_q <= $signed(a_rd_q[EW-1:0])    * $signed(b_rd_q[2*EW-1:EW]);
      p_ir_q <= $signed(a_rd_q[2*EW-1:EW]) * $signed(b_rd_q[EW-1:0]);
    end
  end

  // Move step tags along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q <= '0;
      cmd2_q <= '0;
    end else if (adv) begin
      cmd1_q <= cmd_i;
      cmd2_q <= cmd1_q;
    end
  end

  // Combine products with the conjugate signs and accumulate
  always_comb begin
    rr = C_W'(p_rr_q);
    ii = C_W'(p_ii_q);
    ri = C_W'(p_ri_q);
    ir = C_W'(p_ir_q);
    if (cmd2_q.conj_a) begin
      term_re = rr + ii;
      term_im = ri - ir;
    end else if (cmd2_q.conj_b) begin
      term_re = rr + ii;
      term_im = ir - ri;
    end else begin
      term_re = rr - ii;
      term_im = ri + ir;
    end
    sum_re = (cmd2_q.first ? '0 : acc_re_q) + term_re;
    sum_im = (cmd2_q.first ? '0 : acc_im_q) + term_im;
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd2_q.issue) begin
      acc_re_q <= sum_re;
      acc_im_q <= sum_im;
    end
  end

  // Hold the finished element until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cmd2_q.issue && cmd2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd2_q.issue && cmd2_q.last_k) begin
      c_re_q <= sum_re;
      c_im_q <= sum_im;
      row_q  <= cmd2_q.row;
      col_q  <= cmd2_q.col;
      last_q <= cmd2_q.last_el;
    end
  end

  assign out_valid_o = out_valid_q;
  assign c_re_o      = c_re_q;
  assign c_im_o      = c_im_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> design/complex_matrix_multiply_5x5_unit.sv
// Loads two DIM x DIM complex matrices one element pair per item, then streams
// out their product. While loading, tready stays high and every offered item is
// taken. After the item that completes the load, the block runs DIM*DIM*DIM
// complex multiply-accumulate steps on one shared multiplier, one step per cycle
// while no result item waits on tready. A result item waiting on tready stalls
// the whole pipeline. Loading resumes in the cycle after the last result is taken.
// The mode comes from tuser on the item that completes the load: 0 gives A*B,
// 1 gives A*conjT(B), 2 gives conjT(A)*B, and 3 runs as 0. Results are exact
// 36-bit Q8.28 sums (low 36 bits kept with larger parameters), in row-major
// order, and tlast marks the last one. The element memories hold undefined
// data after reset until loaded. Depends on cmm_pkg, cmm_ctrl and cmm_dp.
`default_nettype none

module complex_matrix_multiply_5x5_unit #(
  parameter int unsigned DIM        = 5,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // a_re, a_im, b_re, b_im (ELEM_WIDTH each, signed), zero pad
  input  wire  [((4*ELEM_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // op (2 bits)
  input  wire  [cmm_pkg::OP_W-1:0]            s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // c_re (36), c_im (36), row (3), col (3), zero pad (2)
  output logic [cmm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);
  import cmm_pkg::*;

  localparam int unsigned EW = ELEM_WIDTH;
  localparam int unsigned AW = $clog2(DIM * DIM);
  localparam int unsigned PAD_W = OUT_TDATA_W - 2 * C_W - 2 * IDX_W;

  logic          in_accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  cmd_t          cmd;
  stat_t         stat;
  logic [C_W-1:0]   c_re, c_im;
  logic [IDX_W-1:0] row, col;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  cmm_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_op_i     (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cmm_dp #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .a_re_i      (s_axis_tdata_i[EW-1:0]),
    .a_im_i      (s_axis_tdata_i[2*EW-1:EW]),
    .b_re_i      (s_axis_tdata_i[3*EW-1:2*EW]),
    .b_im_i      (s_axis_tdata_i[4*EW-1:3*EW]),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .c_re_o      (c_re),
    .c_im_o      (c_im),
    .row_o       (row),
    .col_o       (col),
    .last_o      (m_axis_tlast_o)
  );

  // Pack the result item
  assign m_axis_tdata_o = {{PAD_W{1'b0}}, col, row, c_im, c_re};

endmodule

`default_nettype wire

>>> design/cmm_checker.sv
// Port-level checker of the complex matrix multiply unit and its bind.
// Depends on cmm_pkg and complex_matrix_multiply_5x5_unit_assert.svh.
`default_nettype none

`include "complex_matrix_multiply_5x5_unit_assert.svh"

module cmm_checker #(
  parameter int unsigned DIM = 5
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tready_o,
  input wire                               m_axis_tvalid_o,
  input wire                               m_axis_tready_i,
  input wire [cmm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input wire                               m_axis_tlast_o
);
  import cmm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  // Never take a load item while results are pending
  `CMM_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, s_axis_tready_o, !m_axis_tvalid_o)

  // The marked item is the bottom-right element
  `CMM_ASSERT_SAME(a_last_pos, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o,
    (m_axis_tdata_o[2*C_W+IDX_W-1:2*C_W] == LAST_IDX) &&
    (m_axis_tdata_o[2*C_W+2*IDX_W-1:2*C_W+IDX_W] == LAST_IDX))

  // Loading resumes right after the last result is taken
  `CMM_ASSERT_NEXT(a_reload, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o)

  // A stalled result item holds
  `CMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

endmodule

bind complex_matrix_multiply_5x5_unit cmm_checker #(
  .DIM (DIM)
) u_cmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for complex_matrix_multiply_5x5_unit: loads matrix pairs
// over the input stream and checks every product element against a local predictor.
// Depends on cmm_pkg and the unit under test.
`default_nettype none

module testbench;

  localparam int DIM   = 5;
  localparam int NELEM = DIM * DIM;
  localparam int ELEM_W = 16;
  localparam int CLK_HALF = 6;
  localparam int DRAIN_CYCLES = DIM * DIM * DIM + 16;
  localparam int RANDOM_LOADS = 10;

  // One product element as it leaves the block
  typedef struct packed {
    logic [cmm_pkg::C_W-1:0]   c_re;
    logic [cmm_pkg::C_W-1:0]   c_im;
    logic [cmm_pkg::IDX_W-1:0] row;
    logic [cmm_pkg::IDX_W-1:0] col;
    logic                      last;
  } product_t;

  // Matrix product predictor and store of pending product elements
  class cmm_scoreboard;
    logic signed [ELEM_W-1:0] a_re[NELEM];
    logic signed [ELEM_W-1:0] a_im[NELEM];
    logic signed [ELEM_W-1:0] b_re[NELEM];
    logic signed [ELEM_W-1:0] b_im[NELEM];
    int unsigned fill;
    product_t    product_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned mode_runs[4];

    function new();
      fill = 0;
      mismatches = 0;
      checked = 0;
      foreach (mode_runs[m]) mode_runs[m] = 0;
    endfunction

    function int unsigned pending();
      return product_q.size();
    endfunction

    // Store one element pair; on the completing item queue the whole product
    function void note_input(logic [cmm_pkg::OP_W-1:0] op, logic [4*ELEM_W-1:0] data);
      longint   sr, si, xr, xi, yr, yi;
      int       ia, ib;
      product_t p;
      a_re[fill] = data[0*ELEM_W +: ELEM_W];
      a_im[fill] = data[1*ELEM_W +: ELEM_W];
      b_re[fill] = data[2*ELEM_W +: ELEM_W];
      b_im[fill] = data[3*ELEM_W +: ELEM_W];
      fill++;
      if (fill < NELEM) return;
      fill = 0;
      mode_runs[op]++;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          sr = 0;
          si = 0;
          for (int k = 0; k < DIM; k++) begin
            if (op == cmm_pkg::OP_AHB) begin
              ia = k * DIM + i;
              ib = k * DIM + j;
            end else if (op == cmm_pkg::OP_ABH) begin
              ia = i * DIM + k;
              ib = j * DIM + k;
            end else begin
              ia = i * DIM + k;
              ib = k * DIM + j;
            end
            xr = a_re[ia];
            xi = a_im[ia];
            yr = b_re[ib];
            yi = b_im[ib];
            // conjugate the transposed operand
            if (op == cmm_pkg::OP_AHB) xi = -xi;
            if (op == cmm_pkg::OP_ABH) yi = -yi;
            sr += xr * yr - xi * yi;
            si += xr * yi + xi * yr;
          end
          p.c_re = sr[cmm_pkg::C_W-1:0];
          p.c_im = si[cmm_pkg::C_W-1:0];
          p.row  = i[cmm_pkg::IDX_W-1:0];
          p.col  = j[cmm_pkg::IDX_W-1:0];
          p.last = (i == DIM - 1) && (j == DIM - 1);
          product_q.push_back(p);
        end
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one accepted product element with the oldest pending one
    task check_result(product_t got);
      product_t want;
      if (product_q.size() == 0) begin
        report_mismatch($sformatf("product element row %0d col %0d with none pending",
                                  got.row, got.col));
        return;
      end
      want = product_q.pop_front();
      checked++;
      if (got.c_re !== want.c_re)
        report_mismatch($sformatf("c_re [%0d][%0d]: got %h want %h",
                                  want.row, want.col, got.c_re, want.c_re));
      if (got.c_im !== want.c_im)
        report_mismatch($sformatf("c_im [%0d][%0d]: got %h want %h",
                                  want.row, want.col, got.c_im, want.c_im));
      if (got.row !== want.row)
        report_mismatch($sformatf("row: got %0d want %0d", got.row, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("col: got %0d want %0d", got.col, want.col));
      if (got.last !== want.last)
        report_mismatch($sformatf("tlast [%0d][%0d]: got %b want %b",
                                  want.row, want.col, got.last, want.last));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic [4*ELEM_W-1:0]           s_tdata = '0;
  logic [cmm_pkg::OP_W-1:0]      s_tuser = '0;
  logic                          m_tready = 1'b0;
  logic                          calm = 1'b0;
  wire                           s_tready;
  wire                           m_tvalid;
  wire [cmm_pkg::OUT_TDATA_W-1:0] m_tdata;
  wire                           m_tlast;

  cmm_scoreboard sb = new();

  complex_matrix_multiply_5x5_unit #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  // Clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(400000 * 2 * CLK_HALF);
    $display("Timeout waiting for product elements");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Random back-pressure on the product stream; check every accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    product_t got;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.c_re = m_tdata[0 +: cmm_pkg::C_W];
        got.c_im = m_tdata[cmm_pkg::C_W +: cmm_pkg::C_W];
        got.row  = m_tdata[2*cmm_pkg::C_W +: cmm_pkg::IDX_W];
        got.col  = m_tdata[2*cmm_pkg::C_W+cmm_pkg::IDX_W +: cmm_pkg::IDX_W];
        got.last = m_tlast;
        sb.check_result(got);
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(input logic [cmm_pkg::OP_W-1:0] op,
                           input logic [4*ELEM_W-1:0] data);
    if (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 32);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_input(op, data);
  endtask

  function automatic logic [ELEM_W-1:0] pick_elem(int style);
    logic [ELEM_W-1:0] v;
    case (style)
      1: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      2: v = ELEM_W'($signed($urandom_range(16)) - 8);
      default: v = ELEM_W'($urandom_range(16'hffff));
    endcase
    return v;
  endfunction

  // Load one full matrix pair; the mode rides on the completing item
  task automatic send_load(input logic [cmm_pkg::OP_W-1:0] mode, input int style);
    logic [4*ELEM_W-1:0]      data;
    logic [cmm_pkg::OP_W-1:0] op;
    for (int n = 0; n < NELEM; n++) begin
      for (int f = 0; f < 4; f++) data[f*ELEM_W +: ELEM_W] = pick_elem(style);
      // junk mode on items that do not complete the load
      op = (n == NELEM - 1) ? mode : cmm_pkg::OP_W'($urandom_range(3));
      send_item(op, data);
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [4*ELEM_W-1:0] data;
    logic [ELEM_W-1:0]   ext[4];
    ext[0] = 16'h8000;
    ext[1] = 16'h7fff;
    ext[2] = 16'h0000;
    ext[3] = 16'hffff;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: every field takes each extreme, conjugate of the most negative value
    for (int n = 0; n < NELEM; n++) begin
      data = {ext[(n / 8) % 4], ext[(n / 4) % 4], ext[(n / 2) % 4], ext[n % 4]};
      if (n < 4) data = {4{16'h8000}};
      send_item((n == NELEM - 1) ? cmm_pkg::OP_ABH : cmm_pkg::OP_W'($urandom_range(3)),
                data);
    end

    // Random loads over all modes, including the unused code
    for (int l = 0; l < RANDOM_LOADS; l++) begin
      calm <= (l >= 5 && l <= 7);
      send_load(cmm_pkg::OP_W'(l % 4), (l < 2) ? 1 : $urandom_range(3));
    end
    s_tvalid <= 1'b0;
    calm     <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d product elements from %0d matrix loads", sb.checked,
             RANDOM_LOADS + 1);
    $display("Loads per mode code 0..3: %0d %0d %0d %0d", sb.mode_runs[0],
             sb.mode_runs[1], sb.mode_runs[2], sb.mode_runs[3]);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
